/* rtl/tmb_pkg.sv */
// tmb_pkg: request/result codes, field widths and the channel config word
// for the tick timer bank. No dependencies; used by every other file but tmb_ram.

package tmb_pkg;

  // payload field widths
  localparam int MODE_W  = 3;
  localparam int ID_W    = 4;
  localparam int TICKS_W = 16;
  localparam int KIND_W  = 2;
  localparam int EV_W    = 5;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd3;

  // cap on expiry events reported by one tick
  localparam logic [EV_W-1:0] MAX_EVENTS = 5'd16;

  // per-channel settings written by start
  typedef struct packed {
    logic               periodic;
    logic               notify;
    logic [TICKS_W-1:0] period;
  } tmb_cfg_t;

endpackage

/* rtl/tmb_req_if.sv */
// tmb_req_if: request channel of the tick timer bank (valid/ready plus payload).
// Depends on tmb_pkg for field widths.

interface tmb_req_if;
  logic                        valid;
  logic                        ready;
  logic [tmb_pkg::MODE_W-1:0]  mode;
  logic [tmb_pkg::ID_W-1:0]    timer_id;
  logic [tmb_pkg::TICKS_W-1:0] ticks;
  logic                        repeat_mode;
  logic                        notify;

  modport source (output valid, mode, timer_id, ticks, repeat_mode, notify, input ready);
  modport sink   (input valid, mode, timer_id, ticks, repeat_mode, notify, output ready);
endinterface

/* rtl/tmb_rsp_if.sv */
// tmb_rsp_if: result channel of the tick timer bank (valid/ready plus payload).
// Depends on tmb_pkg for field widths.

interface tmb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tmb_pkg::KIND_W-1:0] kind;
  logic [tmb_pkg::ID_W-1:0]   result_id;
  logic                       flag;
  logic                       last;

  modport source (output valid, kind, result_id, flag, last, input ready);
  modport sink   (input valid, kind, result_id, flag, last, output ready);
endinterface

/* rtl/multi_channel_tick_timer_bank.sv */
// multi_channel_tick_timer_bank: bank of down-counting timer channels.
// Depends on tmb_pkg, tmb_req_if, tmb_rsp_if and tmb_ram.

// A bank of TIMER_COUNT down-counting timers driven by one request beat at a
// time: tick, start, stop, query expired, or allocate id (ids start at 1).
// Start, stop, query, allocate and unknown kinds are answered in the cycle
// the request beat is taken; the result beat is registered and appears in the
// cycle after. A tick walks the allocated channels one per cycle, holding
// in place while the result side stalls an expiry event beat, through a
// single shared decrement-and-compare unit fed by the read port of the count
// memory. Expiry events come out in ascending channel order, at most 16 per
// tick, followed by an acknowledge beat with last set. A new request is
// taken only when the sequencer is idle and the result register is free or
// being drained. Periods and counts live in memories that are never cleared;
// a channel uses them only after a start has written them.

module multi_channel_tick_timer_bank #(
  parameter int TIMER_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tmb_req_if.sink   in_bus,
  tmb_rsp_if.source out_bus
);

  localparam int IDW  = $clog2(TIMER_COUNT);
  localparam int CW   = $clog2(TIMER_COUNT + 1);
  localparam int CMPW = (CW > tmb_pkg::ID_W) ? CW : tmb_pkg::ID_W;
  localparam int TW   = tmb_pkg::TICKS_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_ACK  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [IDW-1:0]             idx_r, idx_nxt;
  logic [tmb_pkg::EV_W-1:0]   ev_cnt_r, ev_cnt_nxt;
  logic [CW-1:0]              alloc_r, alloc_nxt;
  logic [TIMER_COUNT-1:0]     running_r, running_nxt;
  logic [TIMER_COUNT-1:0]     expired_r, expired_nxt;

  logic                       out_valid_r;
  logic [tmb_pkg::KIND_W-1:0] out_kind_r;
  logic [tmb_pkg::ID_W-1:0]   out_id_r;
  logic                       out_flag_r;
  logic                       out_last_r;

  // result register load
  logic                       ld_en;
  logic [tmb_pkg::KIND_W-1:0] ld_kind;
  logic [tmb_pkg::ID_W-1:0]   ld_id;
  logic                       ld_flag;
  logic                       ld_last;

  // memory ports
  logic              cnt_we, per_we, rd_en;
  logic [IDW-1:0]    waddr, raddr;
  logic [TW-1:0]     cnt_wdata, cnt_rdata;
  tmb_pkg::tmb_cfg_t per_wdata, per_rdata;

  logic              can_load, accept;
  logic [CMPW-1:0]   id_x;
  logic [IDW-1:0]    id_a;
  logic              id_ok, start_ok;
  logic              run, hit, emit;
  logic [TW-1:0]     dec;
  logic [CW-1:0]     idx_inc;

  assign can_load     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE) && can_load;
  assign accept       = in_bus.valid && in_bus.ready;

  // request decode helpers
  assign id_x     = CMPW'(in_bus.timer_id);
  assign id_a     = id_x[IDW-1:0];
  assign id_ok    = id_x < CMPW'(TIMER_COUNT);
  assign start_ok = (id_x < CMPW'(alloc_r)) && (in_bus.ticks != '0);

  // shared decrement and zero compare for the channel under evaluation
  assign run     = running_r[idx_r];
  assign dec     = cnt_rdata - TW'(1);
  assign hit     = run && (dec == '0);
  assign emit    = hit && per_rdata.notify && (ev_cnt_r < tmb_pkg::MAX_EVENTS);
  assign idx_inc = CW'(idx_r) + CW'(1);

  assign per_wdata = '{periodic: in_bus.repeat_mode, notify: in_bus.notify,
                       period: in_bus.ticks};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    ev_cnt_nxt  = ev_cnt_r;
    alloc_nxt   = alloc_r;
    running_nxt = running_r;
    expired_nxt = expired_r;
    cnt_we      = 1'b0;
    per_we      = 1'b0;
    waddr       = id_a;
    cnt_wdata   = in_bus.ticks;
    rd_en       = 1'b0;
    raddr       = '0;
    ld_en       = 1'b0;
    ld_kind     = tmb_pkg::KIND_ACK;
    ld_id       = '0;
    ld_flag     = 1'b0;
    ld_last     = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ld_en = 1'b1;
          case (in_bus.mode)
            tmb_pkg::MODE_TICK: begin
              ld_en      = 1'b0;
              rd_en      = 1'b1;
              idx_nxt    = '0;
              ev_cnt_nxt = '0;
              state_nxt  = S_EVAL;
            end
            tmb_pkg::MODE_START: begin
              ld_id   = in_bus.timer_id;
              ld_flag = start_ok;
              if (start_ok) begin
                cnt_we            = 1'b1;
                per_we            = 1'b1;
                running_nxt[id_a] = 1'b1;
                expired_nxt[id_a] = 1'b0;
              end
            end
            tmb_pkg::MODE_STOP: begin
              ld_id = in_bus.timer_id;
              if (id_ok) begin
                running_nxt[id_a] = 1'b0;
              end
            end
            tmb_pkg::MODE_QUERY: begin
              ld_kind = tmb_pkg::KIND_QUERY;
              ld_id   = in_bus.timer_id;
              ld_flag = id_ok && expired_r[id_a];
            end
            tmb_pkg::MODE_ALLOC: begin
              ld_kind = tmb_pkg::KIND_ALLOC;
              if (CMPW'(alloc_r) < CMPW'(TIMER_COUNT)) begin
                ld_id     = tmb_pkg::ID_W'(CMPW'(alloc_r));
                ld_flag   = 1'b1;
                alloc_nxt = alloc_r + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EVAL: begin
        // one channel per cycle, hold in place while an event beat is blocked
        if (!emit || can_load) begin
          if (run) begin
            cnt_we    = 1'b1;
            waddr     = idx_r;
            cnt_wdata = hit ? per_rdata.period : dec;
            if (hit && !per_rdata.periodic) begin
              running_nxt[idx_r] = 1'b0;
              expired_nxt[idx_r] = 1'b1;
            end
          end
          if (emit) begin
            ld_en      = 1'b1;
            ld_kind    = tmb_pkg::KIND_EVENT;
            ld_id      = tmb_pkg::ID_W'(CMPW'(idx_r));
            ld_last    = 1'b0;
            ev_cnt_nxt = ev_cnt_r + tmb_pkg::EV_W'(1);
          end
          if (idx_inc == alloc_r) begin
            state_nxt = S_ACK;
          end else begin
            idx_nxt = IDW'(idx_inc);
            rd_en   = 1'b1;
            raddr   = IDW'(idx_inc);
          end
        end
      end
      S_ACK: begin
        if (can_load) begin
          ld_en     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      ev_cnt_r  <= '0;
      alloc_r   <= CW'(1);
      running_r <= '0;
      expired_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      ev_cnt_r  <= ev_cnt_nxt;
      alloc_r   <= alloc_nxt;
      running_r <= running_nxt;
      expired_r <= expired_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_en) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      out_kind_r <= ld_kind;
      out_id_r   <= ld_id;
      out_flag_r <= ld_flag;
      out_last_r <= ld_last;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.kind      = out_kind_r;
  assign out_bus.result_id = out_id_r;
  assign out_bus.flag      = out_flag_r;
  assign out_bus.last      = out_last_r;

  // remaining ticks per channel
  tmb_ram #(
    .WIDTH (TW),
    .DEPTH (TIMER_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  // period and mode bits per channel
  tmb_ram #(
    .WIDTH ($bits(tmb_pkg::tmb_cfg_t)),
    .DEPTH (TIMER_COUNT)
  ) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (waddr),
    .wdata (per_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (per_rdata)
  );

  // allocation never runs past the bank
  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (alloc_r >= CW'(1)) && (CW'(alloc_r) <= CW'(TIMER_COUNT)))
    else $error("allocated count out of range");

  // event cap per tick
  a_ev_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= tmb_pkg::MAX_EVENTS)
    else $error("too many expiry events in one tick");

  // a request beat is never taken while a result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!out_valid_r || out_bus.ready))
    else $error("request taken while result register blocked");

  // a tick starts the channel walk
  a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_bus.mode == tmb_pkg::MODE_TICK)) |=> (state_r == S_EVAL))
    else $error("tick did not start the channel walk");

  // events carry last low and only appear during the walk
  a_event_src: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_en && (ld_kind == tmb_pkg::KIND_EVENT)) |-> ((state_r == S_EVAL) && !ld_last))
    else $error("expiry event outside the channel walk");

endmodule

/* rtl/tmb_ram.sv */
// tmb_ram: generic single-write, single-read memory with registered read data.
// No dependencies.

module tmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port, read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* dv/timer_bank_checker_pkg.sv */
// timer_bank_checker_pkg: request/result beat types and the checker class that
// predicts and checks the result beats of the tick timer bank.
// Depends on tmb_pkg for widths and codes.
`timescale 1ns / 1ps

package timer_bank_checker_pkg;
  import tmb_pkg::*;

  localparam int NUM_CH      = 16;
  localparam int MAX_REPORTS = 10;

  // request kinds the block answers with a bare acknowledge
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  // channel modes for start
  localparam logic ONE_SHOT = 1'b0;
  localparam logic PERIODIC = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    timer_id;
    logic [TICKS_W-1:0] ticks;
    logic               repeat_mode;
    logic               notify;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   result_id;
    logic              flag;
    logic              last;
  } result_t;

  class timer_bank_checker;
    // shadow of the channel state
    logic [TICKS_W-1:0] period_mem [NUM_CH];
    logic [TICKS_W-1:0] count_mem  [NUM_CH];
    bit                 periodic_bit [NUM_CH];
    bit                 notify_bit   [NUM_CH];
    bit                 running_bit  [NUM_CH];
    bit                 expired_bit  [NUM_CH];
    int unsigned        next_id;

    result_t     expected_beats [$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned expiry_events;
    int unsigned ticks_seen;
    int unsigned starts_ok;
    int unsigned alloc_refused;

    function new();
      for (int i = 0; i < NUM_CH; i++) begin
        period_mem[i]   = '0;
        count_mem[i]    = '0;
        periodic_bit[i] = 1'b0;
        notify_bit[i]   = 1'b0;
        running_bit[i]  = 1'b0;
        expired_bit[i]  = 1'b0;
      end
      next_id       = 1;
      mismatches    = 0;
      beats_checked = 0;
      expiry_events = 0;
      ticks_seen    = 0;
      starts_ok     = 0;
      alloc_refused = 0;
    endfunction

    function int pending_beats();
      return expected_beats.size();
    endfunction

    function void push_beat(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, logic flag,
                            logic last);
      expected_beats.push_back('{kind, id, flag, last});
    endfunction

    // advance the shadow state by one accepted request and queue its results
    function void note_request(request_t r);
      int unsigned n_events;
      bit          ok;
      n_events = 0;
      case (r.mode)
        MODE_TICK: begin
          ticks_seen++;
          for (int i = 0; i < NUM_CH && i < next_id; i++) begin
            if (!running_bit[i]) continue;
            count_mem[i] = count_mem[i] - 1'b1;
            if (count_mem[i] != '0) continue;
            if (periodic_bit[i]) begin
              count_mem[i] = period_mem[i];
            end else begin
              running_bit[i] = 1'b0;
              expired_bit[i] = 1'b1;
            end
            if (notify_bit[i] && n_events < MAX_EVENTS) begin
              push_beat(KIND_EVENT, ID_W'(i), 1'b0, 1'b0);
              n_events++;
            end
          end
          push_beat(KIND_ACK, '0, 1'b0, 1'b1);
        end
        MODE_START: begin
          ok = (r.timer_id < next_id) && (r.ticks != '0);
          if (ok) begin
            period_mem[r.timer_id]   = r.ticks;
            count_mem[r.timer_id]    = r.ticks;
            periodic_bit[r.timer_id] = r.repeat_mode;
            notify_bit[r.timer_id]   = r.notify;
            expired_bit[r.timer_id]  = 1'b0;
            running_bit[r.timer_id]  = 1'b1;
            starts_ok++;
          end
          push_beat(KIND_ACK, r.timer_id, ok, 1'b1);
        end
        MODE_STOP: begin
          running_bit[r.timer_id] = 1'b0;
          push_beat(KIND_ACK, r.timer_id, 1'b0, 1'b1);
        end
        MODE_QUERY: begin
          push_beat(KIND_QUERY, r.timer_id, expired_bit[r.timer_id], 1'b1);
        end
        MODE_ALLOC: begin
          if (next_id < NUM_CH) begin
            push_beat(KIND_ALLOC, ID_W'(next_id), 1'b1, 1'b1);
            next_id++;
          end else begin
            push_beat(KIND_ALLOC, '0, 1'b0, 1'b1);
            alloc_refused++;
          end
        end
        default: push_beat(KIND_ACK, '0, 1'b0, 1'b1);
      endcase
    endfunction

    // compare one result beat against the oldest expectation
    function void check_beat(result_t got);
      result_t want;
      beats_checked++;
      if (got.kind == KIND_EVENT) expiry_events++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: kind=%0d id=%0d flag=%0b last=%0b",
                   $time, got.kind, got.result_id, got.flag, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"[%0t] result beat mismatch: expected kind=%0d id=%0d flag=%0b last=%0b,",
                    " got kind=%0d id=%0d flag=%0b last=%0b"}, $time,
                   want.kind, want.result_id, want.flag, want.last,
                   got.kind, got.result_id, got.flag, got.last);
      end
    endfunction
  endclass

endpackage

/* dv/multi_channel_tick_timer_bank_test.sv */
// multi_channel_tick_timer_bank_test: drives directed and random timer requests
// into the bank and checks every result beat against a shadow of the channels.
// Depends on tmb_pkg, tmb_req_if, tmb_rsp_if, timer_bank_checker_pkg and the RTL.
`timescale 1ns / 1ps

module multi_channel_tick_timer_bank_test;
  import tmb_pkg::*;
  import timer_bank_checker_pkg::*;

  localparam int TOTAL_ITEMS  = 210;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 120;
  localparam int TAIL_CYCLES  = NUM_CH + 4;
  localparam int RESET_CYCLES = 12;

  logic clk;
  logic rst_n;
  bit   quiet;
  int   items_sent;

  tmb_req_if req_bus ();
  tmb_rsp_if rsp_bus ();

  timer_bank_checker bank_chk;

  multi_channel_tick_timer_bank #(
    .TIMER_COUNT(NUM_CH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (req_bus),
    .out_bus (rsp_bus)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // known values on every input from time zero
  initial begin
    rst_n               = 1'b0;
    quiet               = 1'b0;
    items_sent          = 0;
    req_bus.valid       = 1'b0;
    req_bus.mode        = MODE_TICK;
    req_bus.timer_id    = '0;
    req_bus.ticks       = '0;
    req_bus.repeat_mode = ONE_SHOT;
    req_bus.notify      = 1'b0;
    rsp_bus.ready       = 1'b0;
    bank_chk            = new();
  end

  // watch both channels; results first, since a request never answers in its own cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_bus.valid && rsp_bus.ready)
        bank_chk.check_beat('{rsp_bus.kind, rsp_bus.result_id, rsp_bus.flag, rsp_bus.last});
      if (req_bus.valid && req_bus.ready)
        bank_chk.note_request('{req_bus.mode, req_bus.timer_id, req_bus.ticks,
                                req_bus.repeat_mode, req_bus.notify});
    end
  end

  // result side: random stalls, one long hold-off once the bank is busy
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && bank_chk.beats_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= quiet || ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic request_t req_of(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                      logic [TICKS_W-1:0] ticks, logic rep, logic ntf);
    return '{mode, id, ticks, rep, ntf};
  endfunction

  // mostly short periods so channels actually expire
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       span;
    r = '{MODE_W'($urandom_range(MODE_ALLOC, MODE_TICK)),
          ID_W'($urandom_range(NUM_CH - 1, 0)),
          TICKS_W'($urandom_range(6, 1)), 1'($urandom_range(1, 0)),
          1'($urandom_range(1, 0))};
    pick = $urandom_range(99);
    span = $urandom_range(99);
    if (pick < 38)      r.mode = MODE_TICK;
    else if (pick < 68) r.mode = MODE_START;
    else if (pick < 78) r.mode = MODE_STOP;
    else if (pick < 90) r.mode = MODE_QUERY;
    else if (pick < 94) r.mode = MODE_ALLOC;
    else                r.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
    if (span >= 90)      r.ticks = '0;
    else if (span >= 70) r.ticks = TICKS_W'($urandom_range(16'hffff, 0));
    return r;
  endfunction

  // random gap, then hold the beat until the block takes it
  task automatic issue(input request_t r);
    while (!quiet && $urandom_range(99) < 33) begin
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= MODE_W'($urandom_range(7, 0));
      req_bus.timer_id <= ID_W'($urandom_range(NUM_CH - 1, 0));
      req_bus.ticks    <= TICKS_W'($urandom_range(16'hffff, 0));
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.mode        <= r.mode;
    req_bus.timer_id    <= r.timer_id;
    req_bus.ticks       <= r.ticks;
    req_bus.repeat_mode <= r.repeat_mode;
    req_bus.notify      <= r.notify;
    do @(posedge clk); while (!req_bus.ready);
    items_sent++;
  endtask

  task automatic drain_wait();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (bank_chk.pending_beats() != 0);
  endtask

  // every channel armed for one tick, so a single tick reports all of them
  task automatic expire_all_at_once();
    for (int ch = 0; ch < NUM_CH; ch++)
      issue(req_of(MODE_START, ID_W'(ch), 16'd1, 1'($urandom_range(1, 0)), 1'b1));
    issue(req_of(MODE_TICK, '0, '0, ONE_SHOT, 1'b0));
  endtask

  initial begin : stimulus
    bit burst_done;
    bit paused;
    burst_done = 1'b0;
    paused     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fresh state, reserved channel 0, unallocated start, id exhaustion
    issue(req_of(MODE_QUERY, '0, '0, ONE_SHOT, 1'b0));
    issue(req_of(MODE_START, 4'd3, 16'd5, ONE_SHOT, 1'b1));
    issue(req_of(MODE_START, '0, 16'd2, ONE_SHOT, 1'b1));
    issue(req_of(MODE_TICK, '0, '0, ONE_SHOT, 1'b0));
    issue(req_of(MODE_TICK, '0, '0, ONE_SHOT, 1'b0));
    issue(req_of(MODE_QUERY, '0, '0, ONE_SHOT, 1'b0));
    for (int n = 0; n < NUM_CH; n++)
      issue(req_of(MODE_ALLOC, '0, '0, ONE_SHOT, 1'b0));
    issue(req_of(MODE_START, 4'd15, '0, PERIODIC, 1'b1));
    issue(req_of(MODE_START, 4'd15, 16'hffff, PERIODIC, 1'b1));
    issue(req_of(MODE_START, 4'd1, 16'd1, PERIODIC, 1'b1));
    issue(req_of(MODE_TICK, '0, '0, ONE_SHOT, 1'b0));
    issue(req_of(MODE_UNUSED_HI, 4'd15, 16'hffff, PERIODIC, 1'b1));
    issue(req_of(MODE_STOP, 4'd1, '0, ONE_SHOT, 1'b0));
    drain_wait();

    // random traffic with a no-idle window, at least one full-bank expiry and a mid-run drain
    while (items_sent < TOTAL_ITEMS) begin
      quiet = (items_sent >= 90) && (items_sent < 130);
      if ((!burst_done && items_sent >= 110) || $urandom_range(99) < 2) begin
        burst_done = 1'b1;
        expire_all_at_once();
      end else begin
        issue(random_request());
      end
      if (!paused && items_sent >= 160) begin
        paused = 1'b1;
        drain_wait();
      end
    end
    quiet = 1'b0;

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d ticks, %0d accepted starts, %0d refused allocations",
             items_sent, bank_chk.ticks_seen, bank_chk.starts_ok, bank_chk.alloc_refused);
    $display("checked %0d result beats including %0d expiry events, %0d mismatches",
             bank_chk.beats_checked, bank_chk.expiry_events, bank_chk.mismatches);
    if (bank_chk.mismatches == 0 && bank_chk.pending_beats() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("timeout with %0d result beats still expected", bank_chk.pending_beats());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
